### rtl/core/rcpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpa_pkg
// Types, codes and defaults shared by the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rcpa_pkg;

  localparam int unsigned NumPagesDefault  = 32768;
  localparam int unsigned CountBitsDefault = 8;

  localparam int unsigned PageShift  = 12;
  localparam int unsigned FrameW     = 20;
  localparam int unsigned LimitW     = 21;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned KindW      = 3;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned RefCountW  = 8;
  localparam int unsigned CfgIndexW  = 1;

  localparam logic [FrameW-1:0] BasePageReset  = FrameW'(70 + (8 << 16));
  localparam logic [LimitW-1:0] LimitPageReset = LimitW'(557056);

  localparam logic [KindW-1:0] KIND_INIT  = 3'd0;
  localparam logic [KindW-1:0] KIND_ALLOC = 3'd1;
  localparam logic [KindW-1:0] KIND_FREE  = 3'd2;
  localparam logic [KindW-1:0] KIND_PIN   = 3'd3;
  localparam logic [KindW-1:0] KIND_QUERY = 3'd4;

  localparam logic [StatusW-1:0] STATUS_OK          = 3'd0;
  localparam logic [StatusW-1:0] STATUS_BAD_ADDR    = 3'd1;
  localparam logic [StatusW-1:0] STATUS_NO_MEM      = 3'd2;
  localparam logic [StatusW-1:0] STATUS_DOUBLE_FREE = 3'd3;
  localparam logic [StatusW-1:0] STATUS_OVERFLOW    = 3'd4;

  localparam logic [CfgIndexW-1:0] CFG_BASE_PAGE  = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_LIMIT_PAGE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

### rtl/core/refcounted_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Page frame allocator with a reference count per page and a LIFO free stack.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one word: kind and address.
// Output channel (out_valid_o / out_stall_i) returns one word per input word:
// status, page_address, count_is_one and ref_count.
// Configuration: cfg_we_i writes cfg_data_i into base_page (index 0) or
// limit_page (index 1); write only while the block is idle.
// For alloc, free, pin, query and unknown kinds the accept edge reads the count
// memory and the top of the free stack; the execute state then writes the
// updated count and loads the output register.
// Init clears the count memory one entry per cycle, then the execute state
// loads the result.
// After reset the same clearing pass runs with in_stall_o high; configuration
// writes are taken during it.
// A new word is accepted only from the idle state. A result waiting in the
// output register does not block acceptance; a second result waits in the
// execute state until out_stall_i drops.
// ----------------------------------------------------------------------------
module refcounted_page_allocator #(
  parameter int unsigned NumPages  = rcpa_pkg::NumPagesDefault,
  parameter int unsigned CountBits = rcpa_pkg::CountBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rcpa_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [rcpa_pkg::LimitW-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rcpa_pkg::KindW-1:0]        kind_i,
  input  logic [rcpa_pkg::AddrW-1:0]        address_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rcpa_pkg::StatusW-1:0]      status_o,
  output logic [rcpa_pkg::AddrW-1:0]        page_address_o,
  output logic                              count_is_one_o,
  output logic [rcpa_pkg::RefCountW-1:0]    ref_count_o
);
  import rcpa_pkg::*;

  localparam int unsigned IdxW   = (NumPages > 1) ? $clog2(NumPages) : 1;
  localparam int unsigned DepthW = $clog2(NumPages + 1);

  localparam logic [LimitW-1:0]    NumPagesL  = LimitW'(NumPages);
  localparam logic [DepthW-1:0]    NumPagesD  = DepthW'(NumPages);
  localparam logic [IdxW-1:0]      LastIdx    = IdxW'(NumPages - 1);
  localparam logic [CountBits-1:0] CountMax   = {CountBits{1'b1}};
  localparam logic [CountBits-1:0] CountOne   = CountBits'(1);
  localparam logic [CountBits-1:0] CountZero  = '0;

  logic [CountBits-1:0] rc_mem [NumPages];
  logic [IdxW-1:0]      stk_mem [NumPages];

  state_e state_q, state_d;

  logic [IdxW-1:0]      clr_cnt_q, clr_cnt_d;
  logic                 init_rsp_q, init_rsp_d;
  logic [DepthW-1:0]    depth_q, depth_d;
  logic [DepthW-1:0]    fresh_q, fresh_d;
  logic [FrameW-1:0]    base_q;
  logic [LimitW-1:0]    limit_q;
  logic                 out_valid_q;

  logic [KindW-1:0]     kind_q;
  logic [IdxW-1:0]      idx_q;
  logic                 addr_ok_q;
  logic [CountBits-1:0] rc_rd_q;
  logic [IdxW-1:0]      stk_rd_q;
  logic [StatusW-1:0]   status_q, status_d;
  logic [AddrW-1:0]     page_addr_q, page_addr_d;
  logic                 is_one_q, is_one_d;
  logic [RefCountW-1:0] ref_count_q, ref_count_d;

  logic                 in_acc;
  logic                 out_ld;
  logic                 clr_last;

  logic [FrameW-1:0]    frame;
  logic [FrameW-1:0]    frame_off;
  logic                 addr_ok;
  logic [LimitW-1:0]    span;
  logic [LimitW-1:0]    span_cap;

  logic                 rc_we;
  logic [IdxW-1:0]      rc_waddr;
  logic [CountBits-1:0] rc_wdata;
  logic                 stk_we;
  logic [IdxW-1:0]      stk_raddr;

  logic                 from_stack;
  logic [DepthW-1:0]    fresh_m1;
  logic [IdxW-1:0]      alloc_idx;
  logic [FrameW-1:0]    alloc_frame;
  logic [CountBits-1:0] cnt;
  logic [CountBits-1:0] cnt_dec;
  logic [CountBits+RefCountW-1:0] cnt_ext;

  // address check and init span
  assign frame     = address_i[AddrW-1:PageShift];
  assign frame_off = frame - base_q;
  assign addr_ok   = (address_i[PageShift-1:0] == '0) && (frame >= base_q) &&
                     ({1'b0, frame} < limit_q) && ({1'b0, frame_off} < NumPagesL);
  assign span      = (limit_q > {1'b0, base_q}) ? (limit_q - {1'b0, base_q}) : '0;
  assign span_cap  = (span > NumPagesL) ? NumPagesL : span;

  assign clr_last  = (clr_cnt_q == LastIdx);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_ld    = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign stk_raddr = IdxW'(depth_q - DepthW'(1));

  assign from_stack  = (depth_q != '0);
  assign fresh_m1    = fresh_q - DepthW'(1);
  assign alloc_idx   = from_stack ? stk_rd_q : fresh_m1[IdxW-1:0];
  assign alloc_frame = base_q + FrameW'(alloc_idx);
  assign cnt_dec     = rc_rd_q - CountOne;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = init_rsp_q ? ST_EXEC : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_d = (kind_i == KIND_INIT) ? ST_CLEAR : ST_EXEC;
      end
      ST_EXEC: begin
        if (out_ld) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    clr_cnt_d   = clr_cnt_q;
    init_rsp_d  = init_rsp_q;
    depth_d     = depth_q;
    fresh_d     = fresh_q;
    rc_we       = 1'b0;
    rc_waddr    = idx_q;
    rc_wdata    = CountZero;
    stk_we      = 1'b0;
    cnt         = CountZero;
    status_d    = STATUS_OK;
    page_addr_d = '0;
    is_one_d    = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        rc_we     = 1'b1;
        rc_waddr  = clr_cnt_q;
        clr_cnt_d = clr_last ? '0 : clr_cnt_q + IdxW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          init_rsp_d = (kind_i == KIND_INIT);
          if (kind_i == KIND_INIT) begin
            depth_d = '0;
            fresh_d = span_cap[DepthW-1:0];
          end
        end
      end
      ST_EXEC: begin
        unique case (kind_q)
          KIND_INIT: begin
          end
          KIND_ALLOC: begin
            if (from_stack || (fresh_q != '0)) begin
              rc_we       = 1'b1;
              rc_waddr    = alloc_idx;
              rc_wdata    = CountOne;
              cnt         = CountOne;
              page_addr_d = {alloc_frame, {PageShift{1'b0}}};
              if (from_stack) depth_d = depth_q - DepthW'(1);
              else            fresh_d = fresh_m1;
            end else begin
              status_d = STATUS_NO_MEM;
            end
          end
          KIND_FREE: begin
            if (!addr_ok_q) begin
              status_d = STATUS_BAD_ADDR;
            end else if (rc_rd_q == CountZero) begin
              status_d = STATUS_DOUBLE_FREE;
            end else begin
              rc_we    = 1'b1;
              rc_wdata = cnt_dec;
              cnt      = cnt_dec;
              if ((cnt_dec == CountZero) && (depth_q < NumPagesD)) begin
                stk_we  = 1'b1;
                depth_d = depth_q + DepthW'(1);
              end
            end
          end
          KIND_PIN: begin
            if (!addr_ok_q) begin
              status_d = STATUS_BAD_ADDR;
            end else if (rc_rd_q == CountMax) begin
              status_d = STATUS_OVERFLOW;
              cnt      = rc_rd_q;
            end else begin
              rc_we    = 1'b1;
              rc_wdata = rc_rd_q + CountOne;
              cnt      = rc_wdata;
            end
          end
          KIND_QUERY: begin
            if (!addr_ok_q) begin
              status_d = STATUS_BAD_ADDR;
            end else begin
              cnt      = rc_rd_q;
              is_one_d = (rc_rd_q == CountOne);
            end
          end
          default: begin
          end
        endcase
        if (!out_ld) begin
          rc_we   = 1'b0;
          stk_we  = 1'b0;
          depth_d = depth_q;
          fresh_d = fresh_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_ext     = {{RefCountW{1'b0}}, cnt};
  assign ref_count_d = cnt_ext[RefCountW-1:0];

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      init_rsp_q  <= 1'b0;
      depth_q     <= '0;
      fresh_q     <= '0;
      base_q      <= BasePageReset;
      limit_q     <= LimitPageReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      init_rsp_q <= init_rsp_d;
      depth_q    <= depth_d;
      fresh_q    <= fresh_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_BASE_PAGE:  base_q  <= cfg_data_i[FrameW-1:0];
          CFG_LIMIT_PAGE: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_ld)                      out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q    <= kind_i;
      idx_q     <= frame_off[IdxW-1:0];
      addr_ok_q <= addr_ok;
    end
    if (out_ld) begin
      status_q    <= status_d;
      page_addr_q <= page_addr_d;
      is_one_q    <= is_one_d;
      ref_count_q <= ref_count_d;
    end
  end

  // reference count memory
  always_ff @(posedge clk_i) begin
    if (rc_we) rc_mem[rc_waddr] <= rc_wdata;
    if (in_acc) rc_rd_q <= rc_mem[frame_off[IdxW-1:0]];
  end

  // free stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[depth_q[IdxW-1:0]] <= idx_q;
    if (in_acc) stk_rd_q <= stk_mem[stk_raddr];
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign page_address_o = page_addr_q;
  assign count_is_one_o = is_one_q;
  assign ref_count_o    = ref_count_q;

endmodule
